// File: hw/rtl/psr_pkg.sv
// Shared types, constants and blend arithmetic for the palette scanline renderer.
package psr_pkg;

   // Field widths fixed by the block's interface
   localparam int X_W       = 13;
   localparam int CSR_W     = 12;
   localparam int CSR_IDX_W = 2;
   localparam int IDX_W     = 8;
   localparam int CH_W      = 8;
   localparam int RGB_W     = 3 * CH_W;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DRAW_MODE     = 2'd0,
      CSR_BEAM_START    = 2'd1,
      CSR_LINE_PIXELS   = 2'd2,
      CSR_VISIBLE_WIDTH = 2'd3
   } csr_index_type;

   // How a drawn byte turns into output pixels
   typedef enum logic [1:0] {
      PIX_HIRES  = 2'd0,
      PIX_DOUBLE = 2'd1,
      PIX_BLEND  = 2'd2
   } pix_kind_type;

   // Command passed from the front to the back through the command queue
   typedef struct packed {
      logic                 is_write;
      logic [IDX_W-1:0]     index;
      logic [RGB_W-1:0]     rgb;
      logic [X_W-1:0]       x;
      pix_kind_type         kind;
      logic                 clear_prev;
   } cmd_type;

   // One output pixel
   typedef struct packed {
      logic [X_W-1:0]  x;
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            last;
   } rsp_type;

   // Blend weights: (prev * 5 + pal * 95) / 100
   localparam int BLEND_PREV_WEIGHT = 5;
   localparam int BLEND_PAL_WEIGHT  = 95;
   localparam int MIX_W             = 15;
   // Divide by 100 as multiply by 2^19/100 rounded up; exact for sums up to 25500
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = MIX_W + 13;

   function automatic logic [MIX_W-1:0] mix_sum(logic [CH_W-1:0] prev, logic [CH_W-1:0] pal);
      return MIX_W'(prev) * MIX_W'(BLEND_PREV_WEIGHT) + MIX_W'(pal) * MIX_W'(BLEND_PAL_WEIGHT);
   endfunction

   function automatic logic [CH_W-1:0] div100(logic [MIX_W-1:0] sum);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(sum) * PROD_W'(RECIP_100);
      return prod[RECIP_SHIFT +: CH_W];
   endfunction

endpackage

// File: hw/rtl/psr_fifo.sv
// Small register FIFO used for the command queue and the result queue.
module psr_fifo #(
   parameter int  DEPTH      = 4,
   parameter type entry_type = logic
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type pop_data,
   output logic      empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          slots [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slots[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/psr_front.sv
// Front end: configuration registers, line counters and clipping of incoming requests.
module psr_front #(
   parameter int MAX_LINE_PIXELS = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [psr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [psr_pkg::CSR_W-1:0]       csr_wr_data,
   input  logic                            push,
   output logic                            full,
   input  logic                            req_type,
   input  logic [psr_pkg::IDX_W-1:0]       req_color_index,
   input  logic [psr_pkg::CH_W-1:0]        req_pal_red,
   input  logic [psr_pkg::CH_W-1:0]        req_pal_green,
   input  logic [psr_pkg::CH_W-1:0]        req_pal_blue,
   input  logic                            req_line_start,
   output logic                            cmd_push,
   output psr_pkg::cmd_type                cmd_data,
   input  logic                            cmd_full
);
   import psr_pkg::*;

   localparam int CNT_W = $clog2(MAX_LINE_PIXELS + 1);
   localparam int CMP_W = 16;

   localparam logic REQ_PIXEL     = 1'b0;
   localparam logic REQ_PAL_WRITE = 1'b1;

   localparam logic [1:0] MODE_HIRES = 2'd0;
   localparam logic [1:0] MODE_BLEND = 2'd2;
   localparam int         VISIBLE_WIDTH_RESET = 640;

   logic [1:0]         draw_mode_ff, draw_mode_in;
   logic [CSR_W-1:0]   beam_start_ff, beam_start_in;
   logic [CSR_W-1:0]   line_pixels_ff, line_pixels_in;
   logic [CSR_W-1:0]   visible_width_ff, visible_width_in;
   logic [CNT_W-1:0]   src_cnt_ff, src_cnt_in;
   logic               clear_pend_ff, clear_pend_in;

   logic               accept, pixel_accept, is_write;
   logic               bs_neg, bs_pos, lowres, at_max, draw;
   logic [CSR_W-1:0]   abs_bs, off, skip;
   logic signed [CMP_W-1:0] width, width_eff, limit_raw, limit;
   logic signed [CMP_W-1:0] pos_s, skip_s, d_s;
   logic [CNT_W-1:0]   pos;
   logic [X_W-1:0]     x_step;
   pix_kind_type       kind;

   assign full         = cmd_full;
   assign accept       = push && !cmd_full;
   assign is_write     = (req_type == REQ_PAL_WRITE);
   assign pixel_accept = accept && (req_type == REQ_PIXEL);

   // configuration writes
   always_comb begin
      draw_mode_in     = draw_mode_ff;
      beam_start_in    = beam_start_ff;
      line_pixels_in   = line_pixels_ff;
      visible_width_in = visible_width_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_DRAW_MODE:     draw_mode_in     = csr_wr_data[1:0];
            CSR_BEAM_START:    beam_start_in    = csr_wr_data;
            CSR_LINE_PIXELS:   line_pixels_in   = csr_wr_data;
            CSR_VISIBLE_WIDTH: visible_width_in = csr_wr_data;
            default:           draw_mode_in     = draw_mode_ff;
         endcase
      end
   end

   // mode decode; the unused code behaves as doubled
   always_comb begin
      unique case (draw_mode_ff)
         MODE_HIRES: kind = PIX_HIRES;
         MODE_BLEND: kind = PIX_BLEND;
         default:    kind = PIX_DOUBLE;
      endcase
   end
   assign lowres = (kind != PIX_HIRES);

   // clip window from beam start, line length and visible width
   assign bs_neg    = beam_start_ff[CSR_W-1];
   assign bs_pos    = !bs_neg && (beam_start_ff != '0);
   assign abs_bs    = bs_neg ? (~beam_start_ff + CSR_W'(1)) : beam_start_ff;
   assign off       = bs_pos ? beam_start_ff : '0;
   assign skip      = bs_neg ? abs_bs : '0;
   assign width     = signed'(CMP_W'(visible_width_ff)) - signed'(CMP_W'(off));
   assign width_eff = lowres ? (width >>> 1) : width;
   assign limit_raw = signed'(CMP_W'(line_pixels_ff)) - signed'(CMP_W'(abs_bs));
   assign limit     = (limit_raw > width_eff) ? width_eff : limit_raw;

   // position of this byte within the line
   assign pos    = req_line_start ? '0 : src_cnt_ff;
   assign at_max = (pos >= CNT_W'(MAX_LINE_PIXELS));
   assign pos_s  = signed'(CMP_W'(pos));
   assign skip_s = signed'(CMP_W'(skip));
   assign d_s    = pos_s - skip_s;
   assign draw   = !at_max && (pos_s >= skip_s) && (d_s < limit);
   assign x_step = lowres ? (X_W'(d_s) << 1) : X_W'(d_s);

   // counters
   always_comb begin
      src_cnt_in    = src_cnt_ff;
      clear_pend_in = clear_pend_ff;
      if (pixel_accept) begin
         src_cnt_in    = at_max ? pos : pos + CNT_W'(1);
         clear_pend_in = draw ? 1'b0 : (clear_pend_ff || req_line_start);
      end
   end

   // command to the back end
   assign cmd_push = accept && (is_write || draw);
   always_comb begin
      cmd_data.is_write   = is_write;
      cmd_data.index      = req_color_index;
      cmd_data.rgb        = {req_pal_red, req_pal_green, req_pal_blue};
      cmd_data.x          = X_W'(off) + x_step;
      cmd_data.kind       = kind;
      cmd_data.clear_prev = clear_pend_ff || req_line_start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_mode_ff     <= MODE_HIRES;
         beam_start_ff    <= '0;
         line_pixels_ff   <= '0;
         visible_width_ff <= CSR_W'(VISIBLE_WIDTH_RESET);
         src_cnt_ff       <= '0;
         clear_pend_ff    <= 1'b0;
      end else begin
         draw_mode_ff     <= draw_mode_in;
         beam_start_ff    <= beam_start_in;
         line_pixels_ff   <= line_pixels_in;
         visible_width_ff <= visible_width_in;
         src_cnt_ff       <= src_cnt_in;
         clear_pend_ff    <= clear_pend_in;
      end
   end

endmodule

// File: hw/rtl/psr_back.sv
// Back end: palette memory, blend datapath and pixel sequencer.
module psr_back #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   input  psr_pkg::cmd_type  cmd_data,
   input  logic              out_full,
   output logic              out_push,
   output psr_pkg::rsp_type  out_data
);
   import psr_pkg::*;

   localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_READ   = 6'b000010,
      ST_DIV1   = 6'b000100,
      ST_EMIT_A = 6'b001000,
      ST_DIV2   = 6'b010000,
      ST_EMIT_B = 6'b100000
   } state_type;

   logic [RGB_W-1:0]       palette_mem [PALETTE_ENTRIES];
   logic [RGB_W-1:0]       rd_data_ff;

   state_type              state_ff, state_in;
   logic [2:0][CH_W-1:0]   prev_ff, prev_in;
   logic [2:0][CH_W-1:0]   pal_ff, pal_in;
   logic [2:0][CH_W-1:0]   out_rgb_ff, out_rgb_in;
   logic [2:0][MIX_W-1:0]  sum_ff, sum_in;
   logic [X_W-1:0]         x_ff, x_in;
   pix_kind_type           kind_ff, kind_in;
   logic                   ok_ff, ok_in;

   logic                   in_range, mem_we, mem_re;
   logic [PAL_AW-1:0]      mem_addr;
   logic [2:0][CH_W-1:0]   pal_rd;
   logic [2:0][CH_W-1:0]   quot;

   assign in_range = ({1'b0, cmd_data.index} < (IDX_W + 1)'(PALETTE_ENTRIES));
   assign mem_addr = cmd_data.index[PAL_AW-1:0];
   // out-of-range entries read as black
   assign pal_rd   = ok_ff ? rd_data_ff : '0;

   // per-channel divide by 100
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         quot[c] = div100(sum_ff[c]);
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      prev_in    = prev_ff;
      pal_in     = pal_ff;
      out_rgb_in = out_rgb_ff;
      sum_in     = sum_ff;
      x_in       = x_ff;
      kind_in    = kind_ff;
      ok_in      = ok_ff;
      cmd_pop    = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      out_push   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd_data.is_write) begin
                  mem_we = in_range;
               end else begin
                  mem_re   = in_range;
                  ok_in    = in_range;
                  x_in     = cmd_data.x;
                  kind_in  = cmd_data.kind;
                  if (cmd_data.clear_prev) begin
                     prev_in = '0;
                  end
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            pal_in = pal_rd;
            if (kind_ff == PIX_BLEND) begin
               for (int c = 0; c < 3; c++) begin
                  sum_in[c] = mix_sum(prev_ff[c], pal_rd[c]);
               end
               state_in = ST_DIV1;
            end else begin
               out_rgb_in = pal_rd;
               state_in   = ST_EMIT_A;
            end
         end
         ST_DIV1: begin
            out_rgb_in = quot;
            state_in   = ST_EMIT_A;
         end
         ST_EMIT_A: begin
            out_push = !out_full;
            if (!out_full) begin
               priority if (kind_ff == PIX_HIRES) begin
                  state_in = ST_IDLE;
               end else if (kind_ff == PIX_BLEND) begin
                  // second pixel blends the first one with the palette color
                  for (int c = 0; c < 3; c++) begin
                     sum_in[c] = mix_sum(out_rgb_ff[c], pal_ff[c]);
                  end
                  state_in = ST_DIV2;
               end else begin
                  state_in = ST_EMIT_B;
               end
            end
         end
         ST_DIV2: begin
            out_rgb_in = quot;
            prev_in    = quot;
            state_in   = ST_EMIT_B;
         end
         ST_EMIT_B: begin
            out_push = !out_full;
            if (!out_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result fields
   always_comb begin
      out_data.x     = x_ff + X_W'(state_ff == ST_EMIT_B);
      out_data.red   = out_rgb_ff[2];
      out_data.green = out_rgb_ff[1];
      out_data.blue  = out_rgb_ff[0];
      out_data.last  = (state_ff == ST_EMIT_B) || (kind_ff == PIX_HIRES);
   end

   // palette memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[mem_addr] <= cmd_data.rgb;
      end
      if (mem_re) begin
         rd_data_ff <= palette_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         prev_ff  <= '0;
      end else begin
         state_ff <= state_in;
         prev_ff  <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      pal_ff     <= pal_in;
      out_rgb_ff <= out_rgb_in;
      sum_ff     <= sum_in;
      x_ff       <= x_in;
      kind_ff    <= kind_in;
      ok_ff      <= ok_in;
   end

endmodule

// File: hw/rtl/palette_scanline_renderer.sv
// Top level of the palette scanline renderer: front end, command queue, back end, result queue.
//
// Usage: requests enter through push/full; each is either a palette write (req_type 1,
// address in req_color_index, color in req_pal_*) or one 8-bit color index of a scanline
// (req_type 0, req_line_start on the first byte of a line). Output pixels leave through
// empty/pop with their column and an end-of-request flag; a request that is clipped or is
// a palette write produces no pixel. Configuration goes through csr_wr_en/csr_index/
// csr_wr_data and must be written only while the block is idle; the block does not enforce this.
// The back-end sequencer takes one request at a time: a palette write is done in the idle
// state, a hires pixel passes the read and emit states, a doubled pixel pair adds a second
// emit, and a blended pair adds two divide-by-100 steps through registered multipliers.
// Clipped bytes are consumed by the front end at one per cycle while the command queue is
// not full, and do not enter the back end.
// Reset clears the queues, line counters and blend color and loads the configuration
// defaults; palette contents are undefined until written. When the receiver stops popping,
// the result queue fills, the back end holds, then the command queue fills and full rises.
module palette_scanline_renderer #(
   parameter int PALETTE_ENTRIES = 256,
   parameter int MAX_LINE_PIXELS = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [psr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [psr_pkg::CSR_W-1:0]      csr_wr_data,
   input  logic                           push,
   output logic                           full,
   input  logic                           req_type,
   input  logic [psr_pkg::IDX_W-1:0]      req_color_index,
   input  logic [psr_pkg::CH_W-1:0]       req_pal_red,
   input  logic [psr_pkg::CH_W-1:0]       req_pal_green,
   input  logic [psr_pkg::CH_W-1:0]       req_pal_blue,
   input  logic                           req_line_start,
   output logic                           empty,
   input  logic                           pop,
   output logic [psr_pkg::X_W-1:0]        rsp_x_position,
   output logic [psr_pkg::CH_W-1:0]       rsp_red,
   output logic [psr_pkg::CH_W-1:0]       rsp_green,
   output logic [psr_pkg::CH_W-1:0]       rsp_blue,
   output logic                           rsp_last_of_item
);
   import psr_pkg::*;

   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   cmd_type cmd_wr_data, cmd_rd_data;
   rsp_type rsp_wr_data, rsp_rd_data;
   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic    rsp_push, rsp_full;

   // request classification and line counters
   psr_front #(
      .MAX_LINE_PIXELS (MAX_LINE_PIXELS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .push            (push),
      .full            (full),
      .req_type        (req_type),
      .req_color_index (req_color_index),
      .req_pal_red     (req_pal_red),
      .req_pal_green   (req_pal_green),
      .req_pal_blue    (req_pal_blue),
      .req_line_start  (req_line_start),
      .cmd_push        (cmd_push),
      .cmd_data        (cmd_wr_data),
      .cmd_full        (cmd_full)
   );

   // command queue between front and back
   psr_fifo #(
      .DEPTH      (CMD_DEPTH),
      .entry_type (cmd_type)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_wr_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_rd_data),
      .empty     (cmd_empty)
   );

   // palette lookup and pixel generation
   psr_back #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_rd_data),
      .out_full  (rsp_full),
      .out_push  (rsp_push),
      .out_data  (rsp_wr_data)
   );

   // result queue toward the receiver
   psr_fifo #(
      .DEPTH      (RSP_DEPTH),
      .entry_type (rsp_type)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_wr_data),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_rd_data),
      .empty     (empty)
   );

   assign rsp_x_position   = rsp_rd_data.x;
   assign rsp_red          = rsp_rd_data.red;
   assign rsp_green        = rsp_rd_data.green;
   assign rsp_blue         = rsp_rd_data.blue;
   assign rsp_last_of_item = rsp_rd_data.last;

endmodule
